// ===== rtl/nec_ir_pkg.sv =====
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared constants, key table and types of the NEC infrared remote decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nec_ir_pkg;

    localparam int unsigned FRAME_EDGES    = 34;
    localparam int unsigned CMD_FIRST_EDGE = 18;
    localparam int unsigned CMD_BITS       = 8;
    localparam int unsigned KEY_COUNT      = 15;
    localparam int unsigned EDGE_W         = 6;
    localparam int unsigned KEY_W          = 4;
    localparam int unsigned TIME_W         = 32;

    // Interval windows in microseconds, bounds exclusive.
    localparam logic signed [TIME_W-1:0] LEAD_LO = 32'sd13000;
    localparam logic signed [TIME_W-1:0] LEAD_HI = 32'sd14000;
    localparam logic signed [TIME_W-1:0] REP_LO  = 32'sd11000;
    localparam logic signed [TIME_W-1:0] REP_HI  = 32'sd12000;
    localparam logic signed [TIME_W-1:0] BIT0_LO = 32'sd1000;
    localparam logic signed [TIME_W-1:0] BIT0_HI = 32'sd1500;
    localparam logic signed [TIME_W-1:0] BIT1_LO = 32'sd2000;
    localparam logic signed [TIME_W-1:0] BIT1_HI = 32'sd2500;

    localparam logic [TIME_W-1:0] TICK_US = 32'd10;

    // Edge index after a lead code.
    localparam logic [EDGE_W-1:0] LEAD_EDGE = 6'd2;

    localparam logic [CMD_BITS-1:0] KEY_TABLE [KEY_COUNT] = '{
        8'h16, 8'h0C, 8'h18, 8'h5E, 8'h08, 8'h1C, 8'h5A, 8'h42,
        8'h52, 8'h4A, 8'h46, 8'h15, 8'h44, 8'h43, 8'h40
    };

    typedef struct packed {
        logic lead;
        logic rep;
        logic bit_hit;
        logic bit_value;
    } interval_class_t;

    typedef struct packed {
        logic                key_matched;
        logic [KEY_W-1:0]    key_number;
        logic [CMD_BITS-1:0] command_byte;
        logic                repeat_seen;
        logic                lead_seen;
        logic                frame_done;
    } result_t;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_count;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/nec_ir_interval.sv =====
// ----------------------------------------------------------------------------
// NEC IR interval classifier
// Forms the signed interval between an edge and the one before it and sorts
// it into the lead, repeat and data bit windows.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_interval
(
    input  wire logic [31:0]                  now_us,
    input  wire logic [31:0]                  prev_us,
    input  wire logic                         active,
    output nec_ir_pkg::interval_class_t       cls
);

    logic signed [31:0] delta;
    logic               in_lead;
    logic               in_rep;
    logic               in_bit0;
    logic               in_bit1;

    // The difference wraps; read as signed, a negative interval hits no window.
    assign delta   = signed'(now_us - prev_us);
    assign in_lead = (delta > nec_ir_pkg::LEAD_LO) && (delta < nec_ir_pkg::LEAD_HI);
    assign in_rep  = (delta > nec_ir_pkg::REP_LO)  && (delta < nec_ir_pkg::REP_HI);
    assign in_bit0 = (delta > nec_ir_pkg::BIT0_LO) && (delta < nec_ir_pkg::BIT0_HI);
    assign in_bit1 = (delta > nec_ir_pkg::BIT1_LO) && (delta < nec_ir_pkg::BIT1_HI);

    assign cls.lead      = active && in_lead;
    assign cls.rep       = active && in_rep;
    assign cls.bit_hit   = active && (in_bit0 || in_bit1);
    assign cls.bit_value = in_bit1;

endmodule

`default_nettype wire

// ===== rtl/nec_ir_key_lookup.sv =====
// ----------------------------------------------------------------------------
// NEC IR key lookup
// Parallel match of a command byte against the fixed key table.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_key_lookup
(
    input  wire logic [7:0] command_byte,
    output logic            hit,
    output logic [3:0]      number
);

    always_comb
    begin
        hit    = 1'b0;
        number = '0;
        for (int k = 0; k < nec_ir_pkg::KEY_COUNT; k++)
        begin
            if (nec_ir_pkg::KEY_TABLE[k] == command_byte)
            begin
                hit    = 1'b1;
                number = 4'(k);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nec_ir_frame.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame tracker
// Holds the edge time, edge index, command bits and last key, and works out
// the result of one edge in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_frame
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic [31:0]          edge_time,
    output nec_ir_pkg::result_t       res,
    output nec_ir_pkg::status_t       status
);

    logic [31:0] prev_us_reg;
    logic [31:0] prev_us_next;
    logic [5:0]  edge_count_reg;
    logic [5:0]  edge_count_next;
    logic [7:0]  command_bits_reg;
    logic [7:0]  command_bits_next;
    logic [3:0]  last_key_reg;
    logic [3:0]  last_key_next;

    logic [31:0]                 now_us;
    nec_ir_pkg::interval_class_t cls;
    logic [6:0]                  count_inc;
    logic [5:0]                  cmd_off;
    logic                        done;
    logic                        key_hit;
    logic [3:0]                  key_num;

    assign now_us = edge_time * nec_ir_pkg::TICK_US;

    nec_ir_interval u_interval
    (
        .now_us  (now_us),
        .prev_us (prev_us_reg),
        .active  (edge_count_reg != '0),
        .cls     (cls)
    );

    assign prev_us_next = now_us;
    assign cmd_off      = edge_count_reg - 6'(nec_ir_pkg::CMD_FIRST_EDGE);
    assign count_inc    = {1'b0, edge_count_reg} + 7'd1;

    always_comb
    begin
        command_bits_next = command_bits_reg;
        if (cls.bit_hit && (cmd_off < 6'(nec_ir_pkg::CMD_BITS)))
        begin
            command_bits_next[cmd_off[2:0]] = cls.bit_value;
        end
    end

    // A lead, a repeat or the frame end resets the index; else it counts on.
    always_comb
    begin
        done = 1'b0;
        priority if (cls.lead)
        begin
            edge_count_next = nec_ir_pkg::LEAD_EDGE;
        end
        else if (cls.rep)
        begin
            edge_count_next = '0;
        end
        else if (count_inc >= 7'(nec_ir_pkg::FRAME_EDGES))
        begin
            done            = 1'b1;
            edge_count_next = '0;
        end
        else
        begin
            edge_count_next = 6'(count_inc);
        end
    end

    nec_ir_key_lookup u_key_lookup
    (
        .command_byte (command_bits_next),
        .hit          (key_hit),
        .number       (key_num)
    );

    assign last_key_next = (done && key_hit) ? key_num : last_key_reg;

    assign res.frame_done   = done;
    assign res.lead_seen    = cls.lead;
    assign res.repeat_seen  = cls.rep;
    assign res.command_byte = command_bits_next;
    assign res.key_number   = last_key_next;
    assign res.key_matched  = done && key_hit;

    assign status.edge_count = edge_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_us_reg      <= '0;
            edge_count_reg   <= '0;
            command_bits_reg <= '0;
            last_key_reg     <= '0;
        end
        else if (advance)
        begin
            prev_us_reg      <= prev_us_next;
            edge_count_reg   <= edge_count_next;
            command_bits_reg <= command_bits_next;
            last_key_reg     <= last_key_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nec_ir_remote_decoder_top.sv =====
// ----------------------------------------------------------------------------
// NEC IR remote decoder, top level
// Decodes the falling edges of an NEC infrared receiver into frame, lead,
// repeat and key results, one result item per edge item.
// ----------------------------------------------------------------------------
// Each input item carries the time of one falling edge in 10 us ticks and
// yields exactly one result item. The block takes one item per clock cycle
// while the result side does not stall, and its result is registered: an
// input register, then one pass of logic (interval subtract, window compares,
// key match) that updates the frame state and loads the result register.
// Stalls on the result side hold the input register, and input is taken again
// as soon as the result register can move on.
`default_nettype none

module nec_ir_remote_decoder_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] edge_time

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] command_byte, [11:8] key_number,
                                             // [12] key_matched, [15:13] zero
    output logic [1:0]       m_axis_tuser,   // [0] lead_seen, [1] repeat_seen
    output logic             m_axis_tlast    // frame_done
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [31:0]         in_time_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    nec_ir_pkg::result_t out_res_reg;

    logic                s_accept;
    logic                advance;
    nec_ir_pkg::result_t frame_res;
    nec_ir_pkg::status_t status;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    nec_ir_frame u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .edge_time (in_time_reg),
        .res       (frame_res),
        .status    (status)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_time_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_res_reg <= frame_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg.key_matched, out_res_reg.key_number,
                            out_res_reg.command_byte};
    assign m_axis_tuser  = {out_res_reg.repeat_seen, out_res_reg.lead_seen};
    assign m_axis_tlast  = out_res_reg.frame_done;

    // The edge index never reaches the frame length.
    a_edge_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.edge_count < 6'(nec_ir_pkg::FRAME_EDGES))
        else $error("edge index reached the frame length");

    // A lead code sets the edge index to LEAD_EDGE.
    a_lead_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && frame_res.lead_seen) |=> (status.edge_count == nec_ir_pkg::LEAD_EDGE))
        else $error("lead code did not restart the frame");

    // A key can only match at the end of a frame.
    a_match_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[12]) |-> m_axis_tlast)
        else $error("key match outside frame end");

    // Lead and repeat windows exclude each other.
    a_lead_rep_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("lead and repeat flagged together");

endmodule

`default_nettype wire
